FILE: sv/sbm_pkg.sv
// shared types and constants for the stereo block match unit
`timescale 1ns / 1ps
package sbm_pkg;

  localparam int ROW_W  = 13;
  localparam int LUMA_W = 16;
  localparam int MIN_DIM = 9;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;
  localparam logic [23:0] LUMA_ROUND = 24'd128;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_MAX_DISPARITY = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  disparity;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        row_done;
    logic        frame_done;
  } out_item_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  max_disparity;
  } cfg_t;

  function automatic logic [LUMA_W-1:0] to_luma(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [23:0] s;
    s = 24'(COEF_R) * 24'(r) + 24'(COEF_G) * 24'(g) + 24'(COEF_B) * 24'(b) + LUMA_ROUND;
    return s[23:8];
  endfunction

endpackage

FILE: sv/sbm_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module sbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/sbm_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
module sbm_regs
  import sbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= 12'd640;
      cfg.image_height  <= 13'd480;
      cfg.max_disparity <= 8'd114;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[11:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[12:0];
        REG_MAX_DISPARITY: cfg.max_disparity <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:   prdata = {20'd0, cfg.image_width};
      REG_IMAGE_HEIGHT:  prdata = {19'd0, cfg.image_height};
      REG_MAX_DISPARITY: prdata = {24'd0, cfg.max_disparity};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/sbm_window_ssd.sv
// window scan: reads both line stores and accumulates one candidate ssd
`timescale 1ns / 1ps
module sbm_window_ssd
  import sbm_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int WINDOW_SIZE = 9
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [$clog2(WINDOW_SIZE)-1:0]         top_line,
  input  logic [ROW_W-1:0]                       row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         x,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         c,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         w,
  input  logic [ROW_W-1:0]                       h,
  output logic [$clog2(WINDOW_SIZE*MAX_WIDTH)-1:0] l_addr,
  output logic [$clog2(WINDOW_SIZE*MAX_WIDTH)-1:0] r_addr,
  input  logic [LUMA_W-1:0]                      l_data,
  input  logic [LUMA_W-1:0]                      r_data,
  output logic                                   done,
  output logic [2*LUMA_W+$clog2(WINDOW_SIZE*WINDOW_SIZE)-1:0] sum
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int CS   = CW + 2;
  localparam int RS   = ROW_W + 2;
  localparam int KW   = $clog2(WINDOW_SIZE);
  localparam int AW   = $clog2(WINDOW_SIZE * MAX_WIDTH);
  localparam int HALF = WINDOW_SIZE / 2;
  localparam int SQ_W = 2 * LUMA_W;
  localparam int SUM_W = SQ_W + $clog2(WINDOW_SIZE * WINDOW_SIZE);

  logic              busy;
  logic [KW-1:0]     dy, dx, line;
  logic [ROW_W-1:0]  row_q, h_q;
  logic [CW-1:0]     x_q, c_q, w_q;
  logic signed [RS-1:0] row_s;
  logic signed [CS-1:0] lcol_s, rcol_s;
  logic              row_ok, l_ok, r_ok, last_tap;
  logic              p1_valid, p1_lok, p1_rok, p1_last;
  logic              p2_valid, p2_last;
  logic [LUMA_W-1:0] p2_diff;
  logic              p3_valid, p3_last;
  logic [SQ_W-1:0]   p3_sq;
  logic [LUMA_W-1:0] a, b;

  assign row_s  = $signed(RS'(row_q)) + $signed(RS'(dy)) - $signed(RS'(HALF));
  assign lcol_s = $signed(CS'(x_q)) + $signed(CS'(dx)) - $signed(CS'(HALF));
  assign rcol_s = $signed(CS'(c_q)) + $signed(CS'(dx)) - $signed(CS'(HALF));
  assign row_ok = (row_s >= 0) && (row_s < $signed(RS'(h_q)));
  assign l_ok   = row_ok && (lcol_s >= 0) && (lcol_s < $signed(CS'(w_q)));
  assign r_ok   = row_ok && (rcol_s >= 0) && (rcol_s < $signed(CS'(w_q)));
  assign last_tap = (dy == KW'(WINDOW_SIZE - 1)) && (dx == KW'(WINDOW_SIZE - 1));
  assign l_addr = AW'(AW'(line) * AW'(MAX_WIDTH)) + AW'(lcol_s[CW-1:0]);
  assign r_addr = AW'(AW'(line) * AW'(MAX_WIDTH)) + AW'(rcol_s[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last_tap) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dy    <= '0;
      dx    <= '0;
      line  <= top_line;
      row_q <= row;
      h_q   <= h;
      x_q   <= x;
      c_q   <= c;
      w_q   <= w;
    end else if (busy) begin
      if (dx == KW'(WINDOW_SIZE - 1)) begin
        dx <= '0;
        dy <= dy + KW'(1);
        line <= (line == KW'(WINDOW_SIZE - 1)) ? '0 : line + KW'(1);
      end else begin
        dx <= dx + KW'(1);
      end
    end
  end

  assign a = p1_lok ? l_data : '0;
  assign b = p1_rok ? r_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      p1_valid <= busy;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      done     <= p3_valid && p3_last;
    end
  end

  always_ff @(posedge clk) begin
    p1_lok  <= l_ok;
    p1_rok  <= r_ok;
    p1_last <= busy && last_tap;
    p2_diff <= (a > b) ? a - b : b - a;
    p2_last <= p1_last;
    p3_sq   <= p2_diff * p2_diff;
    p3_last <= p2_last;
    if (start) begin
      sum <= '0;
    end else if (p3_valid) begin
      sum <= sum + SUM_W'(p3_sq);
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("window scan restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (p3_valid && p3_last) |=> done)
    else $error("final tap did not complete the sum");

endmodule

FILE: sv/ssd_stereo_block_match_unit.sv
// top level: line stores, position counters and candidate search control
// an item releasing results scans n = min(x-1, max_disparity) candidates per result column x,
//   a max_disparity of 0 counting as 1; none below column 2
// one item at a time; the window scan reads one tap per cycle from each line store
// no-result items end with their line store write; up to 5 results follow an end-of-line item
// reset clears position counters and loads register defaults; line stores are not cleared
`timescale 1ns / 1ps
module ssd_stereo_block_match_unit
  import sbm_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int WINDOW_SIZE = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CS    = CW + 2;
  localparam int KW    = $clog2(WINDOW_SIZE);
  localparam int AW    = $clog2(WINDOW_SIZE * MAX_WIDTH);
  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int SUM_W = 2 * LUMA_W + $clog2(WINDOW_SIZE * WINDOW_SIZE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LUMA = 3'd1;
  localparam logic [2:0] ST_PIX  = 3'd2;
  localparam logic [2:0] ST_CAND = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  cfg_t cfg;
  logic [CW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [7:0]       d_eff;
  logic [ROW_W:0]   row_end;

  logic [2:0]       state;
  logic [CW-1:0]    col_cnt, xx, cur_x, hi_x, cand_c, best_c, c_lo, c_next;
  logic [ROW_W-1:0] row_cnt, rr, res_row;
  logic [KW-1:0]    wr_line, item_line, top_line;
  logic [CW-1:0]    col_start;
  logic [ROW_W-1:0] row_start;
  logic [KW-1:0]    line_start;
  logic             wrap;
  in_item_t         item;
  logic             accept, last_col, has_res;
  logic [SUM_W-1:0] best_sum, sum;
  logic             eng_start, eng_done, better;
  logic [7:0]       disp;
  logic signed [CS-1:0] lo_s;
  logic [AW-1:0]    wr_addr, l_addr, r_addr;
  logic [LUMA_W-1:0] l_luma, r_luma, l_data, r_data;
  logic             wr_en;

  sbm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  always_comb begin
    if (cfg.image_width < 12'(MIN_DIM)) begin
      w_eff = CW'(MIN_DIM);
    end else if (13'(cfg.image_width) > 13'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.image_width);
    end
    if (cfg.image_height < 13'(MIN_DIM)) begin
      h_eff = ROW_W'(MIN_DIM);
    end else if (cfg.image_height > 13'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
    d_eff = (cfg.max_disparity == 8'd0) ? 8'd1 : cfg.max_disparity;
  end

  assign row_end  = (ROW_W + 1)'(h_eff) + (ROW_W + 1)'(HALF);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign wrap     = (col_cnt >= w_eff) || ((ROW_W + 1)'(row_cnt) >= row_end);
  assign col_start  = wrap ? '0 : col_cnt;
  assign row_start  = wrap ? '0 : row_cnt;
  assign line_start = wrap ? '0 : wr_line;

  // position counters advance as the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      wr_line <= '0;
    end else if (accept) begin
      if (col_start + CW'(1) >= w_eff) begin
        col_cnt <= '0;
        if ((ROW_W + 1)'(row_start) + (ROW_W + 1)'(1) >= row_end) begin
          row_cnt <= '0;
          wr_line <= '0;
        end else begin
          row_cnt <= row_start + ROW_W'(1);
          wr_line <= (line_start == KW'(WINDOW_SIZE - 1)) ? '0 : line_start + KW'(1);
        end
      end else begin
        col_cnt <= col_start + CW'(1);
        row_cnt <= row_start;
        wr_line <= line_start;
      end
    end
  end

  assign l_luma = (item.op == OP_FLUSH) ? '0
                : to_luma(item.left_red, item.left_green, item.left_blue);
  assign r_luma = (item.op == OP_FLUSH) ? '0
                : to_luma(item.right_red, item.right_green, item.right_blue);
  assign wr_en   = (state == ST_LUMA) && (rr < h_eff);
  assign wr_addr = AW'(AW'(item_line) * AW'(MAX_WIDTH)) + AW'(xx);

  assign last_col = (xx == w_eff - CW'(1));
  assign has_res  = (rr >= ROW_W'(HALF)) && ((xx >= CW'(HALF)) || last_col);
  assign lo_s     = $signed(CS'(cur_x)) - $signed(CS'(d_eff));
  assign c_lo     = (lo_s < 1) ? CW'(1) : CW'(lo_s[CW-1:0]);
  assign c_next   = cand_c + CW'(1);
  assign better   = (cand_c == c_lo) || (sum < best_sum);
  assign eng_start = (state == ST_CAND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_LUMA;
        ST_LUMA: state <= has_res ? ST_PIX : ST_IDLE;
        ST_PIX:  state <= (cur_x < CW'(2)) ? ST_OUT : ST_CAND;
        ST_CAND: state <= ST_WAIT;
        ST_WAIT: if (eng_done) state <= (c_next < cur_x) ? ST_CAND : ST_OUT;
        ST_OUT:  if (!out_stall) state <= (cur_x == hi_x) ? ST_IDLE : ST_PIX;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= in_data;
      xx        <= col_start;
      rr        <= row_start;
      item_line <= line_start;
    end
    case (state)
      ST_LUMA: begin
        res_row  <= rr - ROW_W'(HALF);
        top_line <= (item_line == KW'(WINDOW_SIZE - 1)) ? '0 : item_line + KW'(1);
        cur_x    <= (xx >= CW'(HALF)) ? xx - CW'(HALF) : '0;
        hi_x     <= last_col ? w_eff - CW'(1) : xx - CW'(HALF);
      end
      ST_PIX: begin
        cand_c <= c_lo;
        disp   <= '0;
      end
      ST_WAIT: if (eng_done) begin
        if (better) begin
          best_sum <= sum;
          best_c   <= cand_c;
        end
        cand_c <= c_next;
        disp   <= 8'(cur_x - (better ? cand_c : best_c));
      end
      ST_OUT: if (!out_stall) cur_x <= cur_x + CW'(1);
      default: ;
    endcase
  end

  sbm_ram #(.WIDTH(LUMA_W), .DEPTH(WINDOW_SIZE * MAX_WIDTH)) u_left_ram (
    .clk, .wr_en, .wr_addr, .wr_data(l_luma), .rd_addr(l_addr), .rd_data(l_data)
  );

  sbm_ram #(.WIDTH(LUMA_W), .DEPTH(WINDOW_SIZE * MAX_WIDTH)) u_right_ram (
    .clk, .wr_en, .wr_addr, .wr_data(r_luma), .rd_addr(r_addr), .rd_data(r_data)
  );

  sbm_window_ssd #(.MAX_WIDTH(MAX_WIDTH), .WINDOW_SIZE(WINDOW_SIZE)) u_ssd (
    .clk, .rst, .start(eng_start), .top_line, .row(res_row), .x(cur_x), .c(cand_c),
    .w(w_eff), .h(h_eff), .l_addr, .r_addr, .l_data, .r_data, .done(eng_done), .sum
  );

  assign out_valid = (state == ST_OUT);
  assign out_data.disparity  = disp;
  assign out_data.out_row    = res_row[11:0];
  assign out_data.out_col    = 11'(cur_x);
  assign out_data.row_done   = (cur_x == w_eff - CW'(1));
  assign out_data.frame_done = (cur_x == w_eff - CW'(1)) && (res_row == h_eff - ROW_W'(1));

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |-> out_data.row_done)
    else $error("frame end without row end");
  a_accept_luma: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LUMA))
    else $error("accepted beat not written to line stores");
  a_disp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.disparity <= d_eff))
    else $error("disparity beyond search range");

endmodule
